@@ rtl/ebsd_pkg.sv @@
package ebsd_pkg;

   // default sizes
   localparam int CONSOLE_DEPTH_DEF = 256;
   localparam int DATA_DEPTH_DEF    = 1024;
   localparam int MAX_POP_DEF       = 64;

   // stream markers
   localparam logic [7:0] MARK_ENTER = 8'hFC;
   localparam logic [7:0] MARK_LEAVE = 8'hFD;
   localparam logic [7:0] CR_BYTE    = 8'h0D;

   // request kinds
   localparam logic [1:0] REQ_RX       = 2'd0;
   localparam logic [1:0] REQ_POP_CON  = 2'd1;
   localparam logic [1:0] REQ_POP_DATA = 2'd2;

   typedef struct packed {
      logic [1:0] req_type;
      logic [7:0] rx_byte;
      logic [6:0] pop_limit;
   } req_item_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       byte_valid;
      logic       last;
      logic       console_added;
   } rsp_item_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_POP_OUT
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic capture;
      logic rx_commit;
      logic empty_result;
      logic pop_start;
      logic pop_emit;
      logic pop_next;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic is_rx;
      logic is_pop;
      logic pop_none;
      logic last_one;
      logic out_free;
   } status_type;

endpackage

@@ rtl/ebsd_ctrl.sv @@
module ebsd_ctrl import ebsd_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (status.is_pop && !status.pop_none) begin
               state_in = ST_POP_OUT;
            end else if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_POP_OUT: begin
            if (status.out_free && status.last_one) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
         end
         ST_EXEC: begin
            if (status.is_pop && !status.pop_none) begin
               cmd.pop_start = 1'b1;
            end else if (status.out_free) begin
               cmd.rx_commit    = status.is_rx;
               cmd.empty_result = !status.is_rx;
            end
         end
         ST_POP_OUT: begin
            if (status.out_free) begin
               cmd.pop_emit = 1'b1;
               cmd.pop_next = !status.last_one;
            end
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

@@ rtl/ebsd_dp.sv @@
module ebsd_dp import ebsd_pkg::*; #(
   parameter int CONSOLE_DEPTH = CONSOLE_DEPTH_DEF,
   parameter int DATA_DEPTH    = DATA_DEPTH_DEF,
   parameter int MAX_POP       = MAX_POP_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  req_item_type req_data,
   input  logic         rsp_ready,
   input  cmd_type      cmd,
   output status_type   status,
   output logic         rsp_valid,
   output rsp_item_type rsp_data
);

   localparam int CAW = $clog2(CONSOLE_DEPTH);
   localparam int CCW = $clog2(CONSOLE_DEPTH + 1);
   localparam int DAW = $clog2(DATA_DEPTH);
   localparam int DCW = $clog2(DATA_DEPTH + 1);
   localparam int PW  = $clog2(MAX_POP + 1);

   req_item_type req_ff;

   logic [7:0] con_mem [CONSOLE_DEPTH];
   logic [7:0] dat_mem [DATA_DEPTH];
   logic [7:0] con_rd_ff;
   logic [7:0] dat_rd_ff;

   logic           mode_ff, mode_in;
   logic [CAW-1:0] con_wp_ff, con_wp_in, con_rp_ff, con_rp_in;
   logic [CCW-1:0] con_cnt_ff, con_cnt_in;
   logic [DAW-1:0] dat_wp_ff, dat_wp_in, dat_rp_ff, dat_rp_in;
   logic [DCW-1:0] dat_cnt_ff, dat_cnt_in;
   logic [PW-1:0]  remain_ff, remain_in;

   logic         rsp_valid_ff, rsp_valid_in;
   rsp_item_type rsp_data_ff, rsp_data_in;

   logic          con_we, dat_we, added, mode_next;
   logic          con_wr_en, dat_wr_en, con_re, dat_re, rd_go, pop_con;
   logic [PW-1:0] lim_sat, con_n, dat_n, pop_n;
   logic          out_free;

   // request register
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_ff <= req_data;
      end
   end

   // stream decode for a received byte
   always_comb begin
      con_we    = 1'b0;
      dat_we    = 1'b0;
      added     = 1'b0;
      mode_next = mode_ff;
      if (mode_ff) begin
         if (req_ff.rx_byte == MARK_LEAVE) begin
            mode_next = 1'b0;
         end else if (req_ff.rx_byte != CR_BYTE && con_cnt_ff != CCW'(CONSOLE_DEPTH)) begin
            con_we = 1'b1;
            added  = 1'b1;
         end
      end else if (req_ff.rx_byte == MARK_ENTER) begin
         mode_next = 1'b1;
      end else if (dat_cnt_ff != DCW'(DATA_DEPTH)) begin
         dat_we = 1'b1;
      end
   end

   assign con_wr_en = cmd.rx_commit & con_we;
   assign dat_wr_en = cmd.rx_commit & dat_we;
   assign mode_in   = cmd.rx_commit ? mode_next : mode_ff;

   assign pop_con = (req_ff.req_type == REQ_POP_CON);
   assign rd_go   = cmd.pop_start | cmd.pop_next;
   assign con_re  = rd_go & pop_con;
   assign dat_re  = rd_go & !pop_con;

   // pop length: saturate limit, clip to fill level
   assign lim_sat = (32'(req_ff.pop_limit) > MAX_POP) ? PW'(MAX_POP) : PW'(req_ff.pop_limit);
   assign con_n   = (32'(con_cnt_ff) < 32'(lim_sat)) ? PW'(con_cnt_ff) : lim_sat;
   assign dat_n   = (32'(dat_cnt_ff) < 32'(lim_sat)) ? PW'(dat_cnt_ff) : lim_sat;
   assign pop_n   = pop_con ? con_n : dat_n;

   // pointers and fill counts
   always_comb begin
      con_wp_in  = con_wp_ff;
      con_rp_in  = con_rp_ff;
      con_cnt_in = con_cnt_ff;
      dat_wp_in  = dat_wp_ff;
      dat_rp_in  = dat_rp_ff;
      dat_cnt_in = dat_cnt_ff;
      if (con_wr_en) begin
         con_wp_in  = (con_wp_ff == CAW'(CONSOLE_DEPTH - 1)) ? '0 : con_wp_ff + 1'b1;
         con_cnt_in = con_cnt_ff + 1'b1;
      end else if (con_re) begin
         con_rp_in  = (con_rp_ff == CAW'(CONSOLE_DEPTH - 1)) ? '0 : con_rp_ff + 1'b1;
         con_cnt_in = con_cnt_ff - 1'b1;
      end
      if (dat_wr_en) begin
         dat_wp_in  = (dat_wp_ff == DAW'(DATA_DEPTH - 1)) ? '0 : dat_wp_ff + 1'b1;
         dat_cnt_in = dat_cnt_ff + 1'b1;
      end else if (dat_re) begin
         dat_rp_in  = (dat_rp_ff == DAW'(DATA_DEPTH - 1)) ? '0 : dat_rp_ff + 1'b1;
         dat_cnt_in = dat_cnt_ff - 1'b1;
      end
   end

   always_comb begin
      remain_in = remain_ff;
      if (cmd.pop_start) begin
         remain_in = pop_n;
      end else if (cmd.pop_emit) begin
         remain_in = remain_ff - 1'b1;
      end
   end

   // output register
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff & !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      if (cmd.pop_emit) begin
         rsp_valid_in              = 1'b1;
         rsp_data_in.out_byte      = pop_con ? con_rd_ff : dat_rd_ff;
         rsp_data_in.byte_valid    = 1'b1;
         rsp_data_in.last          = (remain_ff == PW'(1));
         rsp_data_in.console_added = 1'b0;
      end else if (cmd.rx_commit || cmd.empty_result) begin
         rsp_valid_in              = 1'b1;
         rsp_data_in.out_byte      = '0;
         rsp_data_in.byte_valid    = 1'b0;
         rsp_data_in.last          = 1'b1;
         rsp_data_in.console_added = cmd.rx_commit & added;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= 1'b0;
         con_wp_ff    <= '0;
         con_rp_ff    <= '0;
         con_cnt_ff   <= '0;
         dat_wp_ff    <= '0;
         dat_rp_ff    <= '0;
         dat_cnt_ff   <= '0;
         remain_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         mode_ff      <= mode_in;
         con_wp_ff    <= con_wp_in;
         con_rp_ff    <= con_rp_in;
         con_cnt_ff   <= con_cnt_in;
         dat_wp_ff    <= dat_wp_in;
         dat_rp_ff    <= dat_rp_in;
         dat_cnt_ff   <= dat_cnt_in;
         remain_ff    <= remain_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   // fifo stores, registered read
   always_ff @(posedge clock) begin
      if (con_wr_en) begin
         con_mem[con_wp_ff] <= req_ff.rx_byte;
      end
      if (con_re) begin
         con_rd_ff <= con_mem[con_rp_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (dat_wr_en) begin
         dat_mem[dat_wp_ff] <= req_ff.rx_byte;
      end
      if (dat_re) begin
         dat_rd_ff <= dat_mem[dat_rp_ff];
      end
   end

   assign status.is_rx    = (req_ff.req_type == REQ_RX);
   assign status.is_pop   = pop_con || (req_ff.req_type == REQ_POP_DATA);
   assign status.pop_none = (pop_n == '0);
   assign status.last_one = (remain_ff == PW'(1));
   assign status.out_free = out_free;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

@@ rtl/escape_byte_stream_demux_fifo_top.sv @@
// a received byte, empty pop or unknown request is decoded and its result registered for output
// a pop with bytes to return offers its first byte after the fifo's registered read
// received byte or empty pop: accept, then decode and commit; the next request waits for idle
// pop of n bytes: one byte per cycle from the fifo's registered read port while rsp_ready holds
// reset: synchronous, active high; clears mode, pointers, fill counts and the output valid
// fifo stores are not cleared and need no clearing pass after reset
module escape_byte_stream_demux_fifo_top import ebsd_pkg::*; #(
   parameter int CONSOLE_DEPTH = CONSOLE_DEPTH_DEF,
   parameter int DATA_DEPTH    = DATA_DEPTH_DEF,
   parameter int MAX_POP       = MAX_POP_DEF
) (
   input  logic         clock,
   input  logic         reset,
   // request channel
   input  logic         req_valid,
   output logic         req_ready,
   input  req_item_type req_data,
   // result channel
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_item_type rsp_data
);

   // command and status between sequencer and datapath
   cmd_type    cmd;
   status_type status;

   // sequencer: idle, decode/commit, pop streaming
   ebsd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // datapath: request register, mode flag, two fifos, output register
   ebsd_dp #(
      .CONSOLE_DEPTH (CONSOLE_DEPTH),
      .DATA_DEPTH    (DATA_DEPTH),
      .MAX_POP       (MAX_POP)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

@@ test/ebsd_stream_checker.sv @@
module ebsd_stream_checker import ebsd_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  logic         req_ready,
   input  req_item_type req_data,
   input  logic         rsp_valid,
   input  logic         rsp_ready,
   input  rsp_item_type rsp_data,
   output int           fail_count,
   output int           awaiting,
   output int           results_seen,
   output int           console_stored,
   output int           bytes_popped
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CON_DEPTH = CONSOLE_DEPTH_DEF;
   localparam int DAT_DEPTH = DATA_DEPTH_DEF;
   localparam int POP_MAX   = MAX_POP_DEF;

   // shadow copy of the demux state
   logic       con_mode;
   logic [7:0] con_mem [CON_DEPTH];
   int         con_wr, con_rd, con_cnt;
   logic [7:0] dat_mem [DAT_DEPTH];
   int         dat_wr, dat_rd, dat_cnt;

   rsp_item_type awaited_rsp [$];
   rsp_item_type want;
   int           fails, seen, stored, popped;

   function automatic rsp_item_type make_result(logic [7:0] b, logic v, logic l, logic c);
      rsp_item_type r;
      r.out_byte      = b;
      r.byte_valid    = v;
      r.last          = l;
      r.console_added = c;
      return r;
   endfunction

   // mode switching and fifo fill for one received byte
   task automatic route_rx_byte(input logic [7:0] b);
      logic added;
      added = 1'b0;
      if (con_mode) begin
         if (b == MARK_LEAVE) begin
            con_mode = 1'b0;
         end else if (b != CR_BYTE && con_cnt < CON_DEPTH) begin
            con_mem[con_wr] = b;
            con_wr = (con_wr + 1) % CON_DEPTH;
            con_cnt++;
            added = 1'b1;
            stored++;
         end
      end else if (b == MARK_ENTER) begin
         con_mode = 1'b1;
      end else if (dat_cnt < DAT_DEPTH) begin
         dat_mem[dat_wr] = b;
         dat_wr = (dat_wr + 1) % DAT_DEPTH;
         dat_cnt++;
      end
      awaited_rsp.push_back(make_result(8'h00, 1'b0, 1'b1, added));
   endtask

   // bytes returned by a pop, limit saturated and bounded by the fill count
   task automatic drain_channel(input bit from_console, input logic [6:0] lim);
      int         n;
      logic [7:0] b;
      n = lim;
      if (n > POP_MAX) n = POP_MAX;
      if (from_console && n > con_cnt) n = con_cnt;
      if (!from_console && n > dat_cnt) n = dat_cnt;
      if (n == 0) begin
         awaited_rsp.push_back(make_result(8'h00, 1'b0, 1'b1, 1'b0));
      end
      for (int i = 0; i < n; i++) begin
         if (from_console) begin
            b = con_mem[con_rd];
            con_rd = (con_rd + 1) % CON_DEPTH;
            con_cnt--;
         end else begin
            b = dat_mem[dat_rd];
            dat_rd = (dat_rd + 1) % DAT_DEPTH;
            dat_cnt--;
         end
         popped++;
         awaited_rsp.push_back(make_result(b, 1'b1, (i == n - 1), 1'b0));
      end
   endtask

   initial begin
      fails  = 0;
      seen   = 0;
      stored = 0;
      popped = 0;
   end

   always @(posedge clock) begin
      if (reset) begin
         con_mode = 1'b0;
         con_wr   = 0;
         con_rd   = 0;
         con_cnt  = 0;
         dat_wr   = 0;
         dat_rd   = 0;
         dat_cnt  = 0;
         awaited_rsp.delete();
      end else begin
         // predict first so a same-edge result still finds its entry in order
         if (req_valid && req_ready) begin
            case (req_data.req_type)
               REQ_RX:       route_rx_byte(req_data.rx_byte);
               REQ_POP_CON:  drain_channel(1'b1, req_data.pop_limit);
               REQ_POP_DATA: drain_channel(1'b0, req_data.pop_limit);
               default:      awaited_rsp.push_back(make_result(8'h00, 1'b0, 1'b1, 1'b0));
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            seen++;
            if (awaited_rsp.size() == 0) begin
               fails++;
               if (fails <= 10)
                  $display("%0t: unexpected result byte %02h valid %0b last %0b added %0b",
                           $realtime, rsp_data.out_byte, rsp_data.byte_valid,
                           rsp_data.last, rsp_data.console_added);
            end else begin
               want = awaited_rsp.pop_front();
               if (rsp_data.out_byte !== want.out_byte ||
                   rsp_data.byte_valid !== want.byte_valid ||
                   rsp_data.last !== want.last ||
                   rsp_data.console_added !== want.console_added) begin
                  fails++;
                  if (fails <= 10)
                     $display("%0t: mismatch, expected byte %02h valid %0b last %0b added %0b, got byte %02h valid %0b last %0b added %0b",
                              $realtime, want.out_byte, want.byte_valid, want.last,
                              want.console_added, rsp_data.out_byte, rsp_data.byte_valid,
                              rsp_data.last, rsp_data.console_added);
               end
            end
         end
      end
      fail_count     <= fails;
      awaiting       <= awaited_rsp.size();
      results_seen   <= seen;
      console_stored <= stored;
      bytes_popped   <= popped;
   end

endmodule

@@ test/tb.sv @@
module tb import ebsd_pkg::*; ;
   timeunit 1ns;
   timeprecision 1ps;

   // request kind with no function, must be answered and otherwise ignored
   localparam logic [1:0] REQ_UNUSED = 2'd3;
   // cycles with no handshake on either channel before giving up
   localparam int STALL_LIMIT = 400;

   logic         clock     = 1'b0;
   logic         reset     = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_ready;
   req_item_type req_data  = '0;
   logic         rsp_valid;
   logic         rsp_ready = 1'b0;
   rsp_item_type rsp_data;

   int fail_count, awaiting, results_seen, console_stored, bytes_popped;
   int requests_sent = 0;
   int idle_cycles   = 0;
   bit send_burst    = 1'b0;
   bit take_burst    = 1'b0;

   escape_byte_stream_demux_fifo_top u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // predicts and compares every result on its own
   ebsd_stream_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_data       (rsp_data),
      .fail_count     (fail_count),
      .awaiting       (awaiting),
      .results_seen   (results_seen),
      .console_stored (console_stored),
      .bytes_popped   (bytes_popped)
   );

   // 8 ns clock
   always #4 clock = ~clock;

   // watchdog: ends a run that stops moving
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("no handshake for %0d cycles, %0d results still awaited",
                  idle_cycles, awaiting);
         $display("RESULT: ERROR");
         $finish;
      end
   end

   function automatic req_item_type make_request(logic [1:0] kind, logic [7:0] b,
                                                 logic [6:0] lim);
      req_item_type r;
      r.req_type  = kind;
      r.rx_byte   = b;
      r.pop_limit = lim;
      return r;
   endfunction

   // mostly received bytes with markers often enough to keep switching modes
   function automatic req_item_type random_request();
      req_item_type r;
      int           sel;
      int           pick;
      sel         = $urandom_range(0, 99);
      pick        = $urandom_range(0, 9);
      r.rx_byte   = 8'($urandom);
      r.pop_limit = ($urandom_range(0, 3) == 0) ? 7'($urandom_range(0, 127))
                                                : 7'($urandom_range(0, 10));
      if (sel < 55) begin
         r.req_type = REQ_RX;
         if (pick == 0) r.rx_byte = MARK_ENTER;
         else if (pick == 1) r.rx_byte = MARK_LEAVE;
         else if (pick == 2) r.rx_byte = CR_BYTE;
      end else if (sel < 75) begin
         r.req_type = REQ_POP_CON;
      end else if (sel < 95) begin
         r.req_type = REQ_POP_DATA;
      end else begin
         r.req_type = REQ_UNUSED;
      end
      return r;
   endfunction

   // one request: random gap, then hold valid until accepted
   task automatic send_request(input req_item_type item);
      int gap;
      if ($urandom_range(0, 19) == 0) send_burst = !send_burst;
      gap = send_burst ? 0 : $urandom_range(0, 13);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!(req_valid && req_ready));
      requests_sent++;
   endtask

   // result side: random stall before each result, back-to-back stretches too
   initial begin
      int stall;
      while (reset) @(posedge clock);
      forever begin
         if ($urandom_range(0, 19) == 0) take_burst = !take_burst;
         stall = take_burst ? 0 : $urandom_range(0, 13);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
      end
   end

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // empty channels, with and without a limit
      send_request(make_request(REQ_POP_CON, 8'h00, 7'd5));
      send_request(make_request(REQ_POP_DATA, 8'hFF, 7'd0));
      // normal mode: plain byte, carriage return and leave marker all go to data
      send_request(make_request(REQ_RX, 8'h41, 7'd0));
      send_request(make_request(REQ_RX, CR_BYTE, 7'd0));
      send_request(make_request(REQ_RX, MARK_LEAVE, 7'd0));
      // console mode: carriage return dropped, enter marker is an ordinary byte
      send_request(make_request(REQ_RX, MARK_ENTER, 7'd127));
      send_request(make_request(REQ_RX, 8'h00, 7'd0));
      send_request(make_request(REQ_RX, CR_BYTE, 7'd0));
      send_request(make_request(REQ_RX, MARK_ENTER, 7'd0));
      send_request(make_request(REQ_RX, 8'hFF, 7'd0));
      send_request(make_request(REQ_RX, MARK_LEAVE, 7'd0));
      // unknown request kind with all other bits set
      send_request(make_request(REQ_UNUSED, 8'hFF, 7'd127));
      // zero limit on a filled channel, then a limit above the cap
      send_request(make_request(REQ_POP_CON, 8'h00, 7'd0));
      send_request(make_request(REQ_POP_CON, 8'h00, 7'd127));
      send_request(make_request(REQ_POP_DATA, 8'h00, 7'd1));
      send_request(make_request(REQ_POP_DATA, 8'h00, 7'd64));
      send_request(make_request(REQ_RX, 8'hFF, 7'd0));
      send_request(make_request(REQ_POP_DATA, 8'h00, 7'd127));

      // random mix of bytes, markers and pops
      for (int i = 0; i < 220; i++) send_request(random_request());

      // leave console mode whatever the mix ended in, then empty both channels
      send_request(make_request(REQ_RX, MARK_LEAVE, 7'd0));
      send_request(make_request(REQ_RX, MARK_ENTER, 7'd0));
      send_request(make_request(REQ_RX, MARK_LEAVE, 7'd0));
      for (int i = 0; i < 4; i++) send_request(make_request(REQ_POP_CON, 8'h00, 7'd64));
      for (int i = 0; i < 4; i++) send_request(make_request(REQ_POP_DATA, 8'h00, 7'd64));
      req_valid <= 1'b0;

      // let the count from the last accepted request settle, then wait for every result
      @(posedge clock);
      while (awaiting != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      $display("covered %0d requests and %0d results: %0d bytes popped, %0d console stored",
               requests_sent, results_seen, bytes_popped, console_stored);
      $display("corner cases, a random mix of bytes, markers and pops, then both drained");
      if (fail_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

@@ files.f @@
rtl/ebsd_pkg.sv
rtl/ebsd_ctrl.sv
rtl/ebsd_dp.sv
rtl/escape_byte_stream_demux_fifo_top.sv
test/ebsd_stream_checker.sv
test/tb.sv
